FILE: rtl/psgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psgc_pkg
// Shared types and codes for the per-source sequence gap counter.
// ----------------------------------------------------------------------------
package psgc_pkg;

  // Event modes
  typedef enum logic [1:0] {
    MODE_RECV = 2'd0,
    MODE_PROC = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  localparam int unsigned CNT_W  = 64;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned SRC_W  = 8;
  localparam int unsigned WRK_W  = 8;
  localparam int unsigned MODE_W = 2;

  // Source store write request (address sized for the largest store)
  typedef struct packed {
    logic             en;
    logic [SRC_W-1:0] addr;
    logic [CNT_W-1:0] count;
    logic [SEQ_W-1:0] last;
  } src_wr_t;

  // Source store read data
  typedef struct packed {
    logic             seen;
    logic [CNT_W-1:0] count;
    logic [SEQ_W-1:0] last;
  } src_rd_t;

  // Worker store write request
  typedef struct packed {
    logic             en;
    logic [WRK_W-2:0] addr;
    logic [CNT_W-1:0] count;
  } wrk_wr_t;

endpackage
`default_nettype wire

FILE: rtl/psgc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psgc_if
// Event and result channels of the sequence gap counter (valid/ready).
// ----------------------------------------------------------------------------
interface psgc_evt_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [7:0]             source_index;
  logic [31:0]            sequence_req;
  logic signed [7:0]      worker_index;

  modport source (output valid, mode, source_index, sequence_req, worker_index,
                  input ready);
  modport sink   (input valid, mode, source_index, sequence_req, worker_index,
                  output ready);
endinterface

interface psgc_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] received_total;
  logic [63:0] processed_total;
  logic [63:0] gap_total;
  logic [63:0] source_count;
  logic [63:0] worker_count;
  logic        source_in_range;
  logic        worker_in_range;

  modport source (output valid, received_total, processed_total, gap_total,
                  source_count, worker_count, source_in_range, worker_in_range,
                  input ready);
  modport sink   (input valid, received_total, processed_total, gap_total,
                  source_count, worker_count, source_in_range, worker_in_range,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/psgc_src_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psgc_src_store
// Per-source memory {count, last sequence} with a seen bit per entry.
// An entry never written reads as zero.
// ----------------------------------------------------------------------------
module psgc_src_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output psgc_pkg::src_rd_t      rd_o,
  input  wire psgc_pkg::src_wr_t wr_i
);
  import psgc_pkg::*;

  logic [CNT_W+SEQ_W-1:0] mem [DEPTH];
  logic [CNT_W+SEQ_W-1:0] rd_data_q;
  logic [AW-1:0]          rd_addr_q;
  logic [DEPTH-1:0]       seen_q;
  logic                   seen;

  // Memory port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= {wr_i.count, wr_i.last};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // Seen bits double as entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (wr_i.en) begin
      seen_q[wr_i.addr[AW-1:0]] <= 1'b1;
    end
  end

  assign seen = seen_q[rd_addr_q];

  // Unwritten entries read as zero
  always_comb begin
    rd_o.seen  = seen;
    rd_o.count = seen ? rd_data_q[CNT_W+SEQ_W-1:SEQ_W] : '0;
    rd_o.last  = seen ? rd_data_q[SEQ_W-1:0] : '0;
  end

endmodule
`default_nettype wire

FILE: rtl/psgc_wrk_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psgc_wrk_store
// Per-worker count memory with a valid bit per entry.
// An entry never written reads as zero.
// ----------------------------------------------------------------------------
module psgc_wrk_store #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [AW-1:0]              rd_addr_i,
  output logic [psgc_pkg::CNT_W-1:0]      rd_count_o,
  input  wire psgc_pkg::wrk_wr_t          wr_i
);
  import psgc_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rd_data_q;
  logic [AW-1:0]    rd_addr_q;
  logic [DEPTH-1:0] vld_q;

  // Memory port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.count;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr[AW-1:0]] <= 1'b1;
    end
  end

  assign rd_count_o = vld_q[rd_addr_q] ? rd_data_q : '0;

endmodule
`default_nettype wire

FILE: rtl/per_source_sequence_gap_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_sequence_gap_counter_top
// Counts received messages, sequence gaps and processed items per source
// and per worker; returns one result word per event word.
// ----------------------------------------------------------------------------
// Each event first reads the source and worker memories in the cycle it is
// accepted; the update stage then updates the totals, writes the entries
// back and loads the result register. One event is in the update stage at
// a time, and no new event is accepted until it finishes. The result
// register lets the next event be read while a result waits on the sink;
// a stalled sink holds the update stage. Memories need no clearing pass:
// per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module per_source_sequence_gap_counter_top #(
  parameter int unsigned SOURCE_COUNT = 16,
  parameter int unsigned WORKER_COUNT = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psgc_evt_if.sink    evt_i,
  psgc_res_if.source  res_o
);
  import psgc_pkg::*;

  localparam int unsigned SRC_AW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int unsigned WRK_AW = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;

  // Update stage registers
  logic             busy_q;
  logic [MODE_W-1:0] mode_q;
  logic [SEQ_W-1:0] seq_q;
  logic             src_ok_q;
  logic             wrk_ok_q;
  logic [SRC_W-1:0] src_idx_q;
  logic [WRK_W-2:0] wrk_idx_q;

  // Totals
  logic [CNT_W-1:0] rx_total_q, rx_total_d;
  logic [CNT_W-1:0] proc_total_q, proc_total_d;
  logic [CNT_W-1:0] gap_total_q, gap_total_d;

  // Result register
  logic             res_valid_q;

  logic             accept;
  logic             done;
  logic             src_ok;
  logic             wrk_ok;
  logic             is_rx;
  logic             is_proc;
  logic             rx_upd;
  logic             proc_upd;
  logic [SEQ_W-1:0] seq_diff;
  logic [CNT_W-1:0] gap_add;
  logic [CNT_W-1:0] src_cnt_inc;
  logic [CNT_W-1:0] wrk_cnt_inc;
  logic [CNT_W-1:0] wrk_rd_count;
  src_rd_t          src_rd;
  src_wr_t          src_wr;
  wrk_wr_t          wrk_wr;

  // Range checks on the incoming word
  assign src_ok = ({1'b0, evt_i.source_index} < 9'(SOURCE_COUNT));
  assign wrk_ok = !evt_i.worker_index[WRK_W-1] &&
                  ({1'b0, evt_i.worker_index[WRK_W-2:0]} < 8'(WORKER_COUNT));

  assign evt_i.ready = !busy_q;
  assign accept      = evt_i.valid && evt_i.ready;
  assign done        = busy_q && (!res_valid_q || res_o.ready);

  // Memories
  psgc_src_store #(.DEPTH(SOURCE_COUNT), .AW(SRC_AW)) u_src_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (evt_i.source_index[SRC_AW-1:0]),
    .rd_o      (src_rd),
    .wr_i      (src_wr)
  );

  psgc_wrk_store #(.DEPTH(WORKER_COUNT), .AW(WRK_AW)) u_wrk_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (evt_i.worker_index[WRK_AW-1:0]),
    .rd_count_o (wrk_rd_count),
    .wr_i       (wrk_wr)
  );

  // Capture the event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= evt_i.mode;
      seq_q     <= evt_i.sequence_req;
      src_ok_q  <= src_ok;
      wrk_ok_q  <= wrk_ok;
      src_idx_q <= evt_i.source_index;
      wrk_idx_q <= evt_i.worker_index[WRK_W-2:0];
    end
  end

  // Mode decode; the unused code reads only
  always_comb begin
    is_rx   = 1'b0;
    is_proc = 1'b0;
    unique case (mode_q)
      MODE_RECV: is_rx   = 1'b1;
      MODE_PROC: is_proc = 1'b1;
      default:   ;
    endcase
  end

  assign rx_upd   = is_rx && src_ok_q;
  assign proc_upd = is_proc && wrk_ok_q;

  // Gap: modular distance minus one, only once the source has been seen
  assign seq_diff = seq_q - src_rd.last;
  assign gap_add  = (src_rd.seen && (seq_diff > 32'd1)) ? CNT_W'(seq_diff - 32'd1) : '0;

  assign src_cnt_inc = src_rd.count + 64'd1;
  assign wrk_cnt_inc = wrk_rd_count + 64'd1;

  assign rx_total_d   = rx_total_q + CNT_W'(is_rx);
  assign proc_total_d = proc_total_q + CNT_W'(is_proc);
  assign gap_total_d  = rx_upd ? (gap_total_q + gap_add) : gap_total_q;

  // Write-back
  always_comb begin
    src_wr.en    = done && rx_upd;
    src_wr.addr  = src_idx_q;
    src_wr.count = src_cnt_inc;
    src_wr.last  = seq_q;
    wrk_wr.en    = done && proc_upd;
    wrk_wr.addr  = wrk_idx_q;
    wrk_wr.count = wrk_cnt_inc;
  end

  // Totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_total_q   <= '0;
      proc_total_q <= '0;
      gap_total_q  <= '0;
    end else if (done) begin
      rx_total_q   <= rx_total_d;
      proc_total_q <= proc_total_d;
      gap_total_q  <= gap_total_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (done) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_o.received_total  <= rx_total_d;
      res_o.processed_total <= proc_total_d;
      res_o.gap_total       <= gap_total_d;
      res_o.source_count    <= !src_ok_q ? '0 : (rx_upd ? src_cnt_inc : src_rd.count);
      res_o.worker_count    <= !wrk_ok_q ? '0 : (proc_upd ? wrk_cnt_inc : wrk_rd_count);
      res_o.source_in_range <= src_ok_q;
      res_o.worker_in_range <= wrk_ok_q;
    end
  end

  assign res_o.valid = res_valid_q;

  // Checks
  a_rx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && is_rx) |=> (rx_total_q == $past(rx_total_q) + 64'd1))
    else $error("received total not bumped on a receive event");

  a_proc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !is_proc) |=> $stable(proc_total_q))
    else $error("processed total moved on a non-process event");

  a_gap_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !src_rd.seen) |=> $stable(gap_total_q))
    else $error("gap counted on the first message of a source");

  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(done))
    else $error("result shown without a finished event");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !done) |=> busy_q)
    else $error("update stage dropped an event");

endmodule
`default_nettype wire
